/* rtl/cse_pkg.sv */
`timescale 1ns / 1ps

package cse_pkg;

  // Register map: one 32-bit register per 4-byte slot
  localparam int CoefRegs    = 7;
  localparam int MaxTermsDef = 7;
  localparam int CfgAw       = 5;
  localparam int CfgDw       = 32;

  localparam int XW   = 32;  // Q1.30 sample and polynomial values
  localparam int OutW = 48;  // Q23.24 result

  localparam logic signed [XW-1:0]   OneQ30 = 32'sd1073741824;
  localparam logic signed [OutW-1:0] OneQ24 = 48'sd16777216;

  typedef enum logic [2:0] {
    REG_TERM_COUNT = 3'd0,
    REG_COEF_0     = 3'd1,
    REG_COEF_1     = 3'd2,
    REG_COEF_2     = 3'd3,
    REG_COEF_3     = 3'd4,
    REG_COEF_4     = 3'd5,
    REG_COEF_5     = 3'd6,
    REG_COEF_6     = 3'd7
  } cse_reg_e;

  // Saturate a recurrence result to [-1, 1] in Q1.30
  function automatic logic signed [XW-1:0] clamp_q30(input logic signed [35:0] v);
    logic signed [XW-1:0] r;
    if (v > 36'(OneQ30)) begin
      r = OneQ30;
    end else if (v < -36'(OneQ30)) begin
      r = -OneQ30;
    end else begin
      r = v[XW-1:0];
    end
    return r;
  endfunction

endpackage

/* rtl/chebyshev_series_evaluator_top.sv */
`timescale 1ns / 1ps

// Chebyshev series evaluator: series_value = 1 + sum of coef_k * T_(k+1)(x) for
// k below term_count (capped at MAX_TERMS), Q1.30 sample in, Q23.24 word out.
// Input channel x_value_i / in_valid_i / in_ready_o, output channel series_value_o /
// out_valid_o / out_ready_i; a word moves when valid and ready are both high.
// The recurrence is unrolled into 2*MAX_TERMS + 1 register stages: the entry register,
// per term one multiply stage (x*T and coef*T side by side) and one add stage (next T
// and the running sum; the last one is the output register). The entry register loads
// at the accepting edge, and out_valid_o rises when that word reaches the output register;
// one word is taken every cycle unless the receiver stalls.
// When the receiver stalls with a word waiting, the whole pipeline holds and
// in_ready_o drops; nothing is lost or repeated.
// Registers sit on an APB-style port: term_count at 0x00, coef_0..coef_6 at
// 0x04..0x1C; write them only while no word is in flight.
// Reset clears the pipeline valid bits and the configuration registers, so a word taken right
// after reset returns exactly 1.0.
module chebyshev_series_evaluator_top
  import cse_pkg::*;
#(
  parameter int MAX_TERMS = MaxTermsDef
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  // configuration port
  input  logic                   psel,
  input  logic                   penable,
  input  logic                   pwrite,
  input  logic [CfgAw-1:0]       paddr,
  input  logic [CfgDw-1:0]       pwdata,
  output logic [CfgDw-1:0]       prdata,
  output logic                   pready,
  // sample channel
  input  logic                   in_valid_i,
  output logic                   in_ready_o,
  input  logic signed [XW-1:0]   x_value_i,
  // result channel
  output logic                   out_valid_o,
  input  logic                   out_ready_i,
  output logic signed [OutW-1:0] series_value_o
);

  localparam int N = MAX_TERMS;

  // ---------------------------------------------------------------------------
  // Configuration registers
  // ---------------------------------------------------------------------------
  logic [2:0]              term_count_q;
  logic signed [XW-1:0]    coef_q [CoefRegs];
  cse_reg_e                reg_idx;
  logic [2:0]              coef_idx;
  logic                    cfg_wr;
  logic [2:0]              n_terms;

  assign pready   = 1'b1;
  assign reg_idx  = cse_reg_e'(paddr[4:2]);
  assign coef_idx = 3'(reg_idx) - 3'd1;
  assign cfg_wr   = psel && penable && pwrite && pready;

  // write on the access cycle
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      term_count_q <= '0;
      for (int i = 0; i < CoefRegs; i++) begin
        coef_q[i] <= '0;
      end
    end else if (cfg_wr) begin
      unique case (reg_idx) inside
        REG_TERM_COUNT:           term_count_q     <= pwdata[2:0];
        [REG_COEF_0:REG_COEF_6]:  coef_q[coef_idx] <= $signed(pwdata);
        default:                  term_count_q     <= term_count_q;
      endcase
    end
  end

  // read back
  always_comb begin
    unique case (reg_idx) inside
      REG_TERM_COUNT:          prdata = {29'd0, term_count_q};
      [REG_COEF_0:REG_COEF_6]: prdata = coef_q[coef_idx];
      default:                 prdata = '0;
    endcase
  end

  // cap the count at the number of built stages
  assign n_terms = (term_count_q > 3'(N)) ? 3'(N) : term_count_q;

  // ---------------------------------------------------------------------------
  // Pipeline control: advance everything unless the output word is stuck
  // ---------------------------------------------------------------------------
  logic         adv;
  logic [N-1:0] va_q;   // add-stage valid bits (stage 0 is the entry register)
  logic [N-1:0] vm_q;   // multiply-stage valid bits
  logic         out_valid_q;

  assign adv        = !out_valid_q || out_ready_i;
  assign in_ready_o = adv;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      va_q        <= '0;
      vm_q        <= '0;
      out_valid_q <= 1'b0;
    end else if (adv) begin
      va_q        <= {vm_q[N-2:0], in_valid_i};
      vm_q        <= va_q;
      out_valid_q <= vm_q[N-1];
    end
  end

  // ---------------------------------------------------------------------------
  // Datapath registers
  // ---------------------------------------------------------------------------
  // add-stage outputs: x, T_(k+1), T_k and the running sum
  logic signed [XW-1:0]   xa_q   [N];
  logic signed [XW-1:0]   ta_q   [N];
  logic signed [XW-1:0]   pa_q   [N];
  logic signed [OutW-1:0] acca_q [N];
  // multiply-stage outputs
  logic signed [63:0]     prodt_q [N];
  logic signed [OutW-1:0] accm_q  [N];
  logic signed [XW-1:0]   xm_q    [N-1];
  logic signed [XW-1:0]   tm_q    [N-1];
  logic signed [XW-1:0]   pm_q    [N-1];
  logic signed [63:0]     prodx_q [N-1];
  // rounded, gated term of each stage
  logic signed [OutW-1:0] term_w  [N];
  logic signed [OutW-1:0] series_q;

  logic signed [XW-1:0]   x_clamped;

  // clamp the sample to [-1, 1]
  always_comb begin
    if (x_value_i > OneQ30) begin
      x_clamped = OneQ30;
    end else if (x_value_i < -OneQ30) begin
      x_clamped = -OneQ30;
    end else begin
      x_clamped = x_value_i;
    end
  end

  // entry register: T_1 = x, T_0 = 1, sum = 1
  always_ff @(posedge clk_i) begin
    if (adv) begin
      xa_q[0]   <= x_clamped;
      ta_q[0]   <= x_clamped;
      pa_q[0]   <= OneQ30;
      acca_q[0] <= OneQ24;
    end
  end

  for (genvar k = 0; k < N; k++) begin : g_term
    logic signed [63:0] tsum;
    logic               term_en;

    // multiply: coef_k * T_(k+1)
    always_ff @(posedge clk_i) begin
      if (adv) begin
        prodt_q[k] <= coef_q[k] * ta_q[k];
        accm_q[k]  <= acca_q[k];
      end
    end

    // round the term to Q24, halves up; drop it past the count
    assign tsum      = prodt_q[k] + 64'sd536870912;
    assign term_en   = (3'(k) < n_terms);
    assign term_w[k] = term_en ? OutW'($signed(tsum[63:30])) : '0;

    if (k < N - 1) begin : g_rec
      logic signed [63:0] xsum;
      logic signed [34:0] twice;
      logic signed [35:0] diff;

      // multiply: x * T_(k+1), carry T_(k+1) and T_k along
      always_ff @(posedge clk_i) begin
        if (adv) begin
          prodx_q[k] <= xa_q[k] * ta_q[k];
          xm_q[k]    <= xa_q[k];
          tm_q[k]    <= ta_q[k];
          pm_q[k]    <= pa_q[k];
        end
      end

      // add: T_(k+2) = round(2 x T_(k+1)) - T_k, saturated; accumulate term k
      assign xsum  = prodx_q[k] + 64'sd268435456;
      assign twice = $signed(xsum[63:29]);
      assign diff  = 36'(twice) - 36'(pm_q[k]);

      always_ff @(posedge clk_i) begin
        if (adv) begin
          xa_q[k+1]   <= xm_q[k];
          ta_q[k+1]   <= clamp_q30(diff);
          pa_q[k+1]   <= tm_q[k];
          acca_q[k+1] <= accm_q[k] + term_w[k];
        end
      end
    end
  end

  // output register; the sum stays below 2^35, so the 48-bit limit is never hit
  always_ff @(posedge clk_i) begin
    if (adv) begin
      series_q <= accm_q[N-1] + term_w[N-1];
    end
  end

  assign out_valid_o    = out_valid_q;
  assign series_value_o = series_q;

  // ---------------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------------
  a_stall_holds_stages: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !adv |=> ($stable(va_q) && $stable(vm_q) && $stable(out_valid_q)))
    else $error("pipeline valid bits moved during a stall");

  a_ready_only_when_blocked: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> out_valid_o)
    else $error("input blocked with no word waiting at the output");

  a_result_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (series_value_o[47:35] == 13'h0000 ||
                     series_value_o[47:35] == 13'h1fff))
    else $error("series value beyond the reachable range");

endmodule
